/* hw/rtl/prefix_code_stream_decoder_unit_defines.svh */
// shared assertion macros, sampled on clk and idle while rst_n is low
`ifndef PREFIX_CODE_STREAM_DECODER_UNIT_DEFINES_SVH
`define PREFIX_CODE_STREAM_DECODER_UNIT_DEFINES_SVH

// property checked at every edge
`define PSCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequence checked in the cycle after the antecedent
`define PSCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/pscd_pkg.sv */
`default_nettype none

package pscd_pkg;

    localparam int DEF_MAX_CODE_LEN  = 32;
    localparam int DEF_TABLE_ENTRIES = 256;

    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int SYM_W     = 8;
    localparam int DATA_W    = 8;
    localparam int PAD_W     = 3;
    localparam int BCNT_W    = 4;
    localparam int BYTE_BITS = 8;
    localparam int PAD_MAX   = 7;
    localparam int GRP_SIZE  = 8;

    localparam int REQ_W = 2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DATA  = 2'd2;

    // slave tdata layout
    localparam int SYM_LSB   = 0;
    localparam int LEN_LSB   = SYM_LSB + SYM_W;
    localparam int BITS_LSB  = LEN_LSB + LEN_W;
    localparam int BYTE_LSB  = BITS_LSB + CODE_W;
    localparam int S_FIELD_W = BYTE_LSB + DATA_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = SYM_W;

    typedef struct packed {
        logic              live;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } entry_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } probe_t;

    function automatic logic [CODE_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] m;
        for (int i = 0; i < CODE_W; i++) begin
            m[i] = (int'(len) > i);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pscd_cell.sv */
`default_nettype none

module pscd_cell import pscd_pkg::*; #(
    parameter int IDX_W = 8,
    parameter int IDX   = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             clear,
    input  wire logic             load,
    input  wire entry_t           entry,
    input  wire probe_t           probe,
    input  wire logic             found_in,
    input  wire logic [IDX_W-1:0] idx_in,
    output logic                  found_out,
    output logic [IDX_W-1:0]      idx_out
);

    logic              live_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [CODE_W-1:0] bits_reg;
    logic              match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else if (clear)
        begin
            live_reg <= 1'b0;
        end
        else if (load)
        begin
            live_reg <= entry.live;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            len_reg  <= entry.len;
            bits_reg <= entry.bits;
        end
    end

    assign match = live_reg && (len_reg == probe.len) && (bits_reg == probe.bits);

    // a lower neighbour that already matched keeps priority
    assign found_out = found_in || match;
    assign idx_out   = found_in ? idx_in : IDX_W'(IDX);

endmodule

`default_nettype wire

/* hw/rtl/pscd_cell_row.sv */
`default_nettype none

module pscd_cell_row import pscd_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             clear,
    input  wire logic                             load,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0] load_sym,
    input  wire entry_t                           load_entry,
    input  wire probe_t                           probe,
    input  wire logic                             capture,
    output logic                                  hit_found,
    output logic [$clog2(TABLE_ENTRIES)-1:0]      hit_idx
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int NGRP  = (TABLE_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;

    logic             chain_found [NGRP][GRP_SIZE+1];
    logic [IDX_W-1:0] chain_idx   [NGRP][GRP_SIZE+1];
    logic             grp_found_reg [NGRP];
    logic [IDX_W-1:0] grp_idx_reg   [NGRP];

    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        assign chain_found[g][0] = 1'b0;
        assign chain_idx[g][0]   = '0;

        for (genvar k = 0; k < GRP_SIZE; k++)
        begin : g_pos
            localparam int IDX = g * GRP_SIZE + k;
            if (IDX < TABLE_ENTRIES)
            begin : g_cell
                pscd_cell #(
                    .IDX_W (IDX_W),
                    .IDX   (IDX)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .clear     (clear),
                    .load      (load && (load_sym == IDX_W'(IDX))),
                    .entry     (load_entry),
                    .probe     (probe),
                    .found_in  (chain_found[g][k]),
                    .idx_in    (chain_idx[g][k]),
                    .found_out (chain_found[g][k+1]),
                    .idx_out   (chain_idx[g][k+1])
                );
            end
            else
            begin : g_pad
                assign chain_found[g][k+1] = chain_found[g][k];
                assign chain_idx[g][k+1]   = chain_idx[g][k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                grp_found_reg[g] <= 1'b0;
            end
            else if (capture)
            begin
                grp_found_reg[g] <= chain_found[g][GRP_SIZE];
            end
        end

        always_ff @(posedge clk)
        begin
            if (capture)
            begin
                grp_idx_reg[g] <= chain_idx[g][GRP_SIZE];
            end
        end
    end

    // lowest group with a hit wins
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_found_reg[g])
            begin
                hit_found = 1'b1;
                hit_idx   = grp_idx_reg[g];
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/prefix_code_stream_decoder_unit.sv */
// prefix code stream decoder
// s_axis carries requests: tuser selects clear, table load or packed data byte,
// tlast marks the final data byte of the stream. m_axis returns one decoded
// symbol per transfer, tuser flags a rejected header and tlast marks the last
// symbol caused by one request.
// clear, load, accepted header and ignored requests are handled in idle, a rejected
// header passes through the flush state. a data byte feeds its code bits one by
// one: each bit is shifted into the accumulator and compared across the cell row,
// the group hits are registered and the registered group select resolves them, so
// the compare and select loop sets the rate.
// a symbol is held until the next hit or the end of the byte, and then passes
// through the output register to m_axis.
// the output register lets the next request in while a symbol waits; while
// m_axis stalls with a symbol held back, decoding pauses and s_axis_tready
// stays low.
// reset empties the table and the bit accumulator and returns to idle with
// s_axis_tready high; no clearing pass is needed.
`default_nettype none

module prefix_code_stream_decoder_unit import pscd_pkg::*; #(
    parameter int MAX_CODE_LEN  = DEF_MAX_CODE_LEN,
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // entry_symbol, entry_length, entry_bits, data_byte, zero fill
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  wire logic [REQ_W-1:0]     s_axis_tuser,
    input  wire logic                 s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // out_symbol
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // bad_header
    output logic                      m_axis_tuser,
    output logic                      m_axis_tlast
);

    localparam int IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int ACC_LEN_W = $clog2(MAX_CODE_LEN + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_STEP    = 3'd1;
    localparam logic [2:0] ST_MATCH   = 3'd2;
    localparam logic [2:0] ST_RESOLVE = 3'd3;
    localparam logic [2:0] ST_FLUSH   = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [CODE_W-1:0]    acc_bits_reg, acc_bits_next;
    logic [ACC_LEN_W-1:0] acc_len_reg, acc_len_next;
    logic [PAD_W-1:0]     pad_reg, pad_next;
    logic                 header_seen_reg, header_seen_next;
    logic                 rejected_reg, rejected_next;
    logic                 stuck_reg, stuck_next;
    logic [DATA_W-1:0]    byte_reg, byte_next;
    logic [BCNT_W-1:0]    bits_left_reg, bits_left_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_sym_reg, pend_sym_next;
    logic                 pend_bad_reg, pend_bad_next;
    logic                 out_valid_reg;
    logic [SYM_W-1:0]     out_sym_reg;
    logic                 out_bad_reg;
    logic                 out_last_reg;

    logic                 in_fire;
    logic [SYM_W-1:0]     in_sym;
    logic [LEN_W-1:0]     in_len;
    logic [CODE_W-1:0]    in_bits;
    logic [DATA_W-1:0]    in_byte;
    logic                 load_ok;
    entry_t               load_entry;
    probe_t               probe;
    logic [31:0]          acc_len_wide;

    logic                 cell_clear;
    logic                 cell_load;
    logic                 capture;
    logic                 hit_found;
    logic [IDX_W-1:0]     hit_idx;

    logic                 slot_free;
    logic                 resolve_stall;
    logic                 take_hit;
    logic                 do_step;
    logic [ACC_LEN_W-1:0] acc_len_eff;
    logic [CODE_W-1:0]    acc_bits_eff;
    logic                 push;
    logic [IDX_W-1:0]     push_sym;
    logic                 push_bad;
    logic                 push_last;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign in_sym  = s_axis_tdata[SYM_LSB +: SYM_W];
    assign in_len  = s_axis_tdata[LEN_LSB +: LEN_W];
    assign in_bits = s_axis_tdata[BITS_LSB +: CODE_W];
    assign in_byte = s_axis_tdata[BYTE_LSB +: DATA_W];

    assign load_ok = ({1'b0, in_sym} < (SYM_W + 1)'(TABLE_ENTRIES));

    // entries that can never match are stored with live cleared
    assign load_entry.live = (in_len != '0) && (in_len <= LEN_W'(CODE_W))
                           && (32'(in_len) <= 32'(MAX_CODE_LEN));
    assign load_entry.len  = in_len;
    assign load_entry.bits = in_bits & len_mask(in_len);

    // an accumulator longer than any storable code probes with length zero
    assign acc_len_wide = 32'(acc_len_reg);
    assign probe.len    = (acc_len_wide > 32'(CODE_W)) ? '0 : acc_len_wide[LEN_W-1:0];
    assign probe.bits   = acc_bits_reg;

    pscd_cell_row #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_row (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (cell_clear),
        .load       (cell_load),
        .load_sym   (in_sym[IDX_W-1:0]),
        .load_entry (load_entry),
        .probe      (probe),
        .capture    (capture),
        .hit_found  (hit_found),
        .hit_idx    (hit_idx)
    );

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign resolve_stall = (state_reg == ST_RESOLVE) && hit_found && pend_valid_reg
                         && !slot_free;
    assign take_hit      = (state_reg == ST_RESOLVE) && hit_found && !resolve_stall;
    assign do_step       = (state_reg == ST_STEP)
                         || ((state_reg == ST_RESOLVE) && !resolve_stall);
    assign acc_len_eff   = take_hit ? '0 : acc_len_reg;
    assign acc_bits_eff  = take_hit ? '0 : acc_bits_reg;

    always_comb
    begin
        state_next       = state_reg;
        acc_bits_next    = acc_bits_reg;
        acc_len_next     = acc_len_reg;
        pad_next         = pad_reg;
        header_seen_next = header_seen_reg;
        rejected_next    = rejected_reg;
        stuck_next       = stuck_reg;
        byte_next        = byte_reg;
        bits_left_next   = bits_left_reg;
        pend_valid_next  = pend_valid_reg;
        pend_sym_next    = pend_sym_reg;
        pend_bad_next    = pend_bad_reg;
        cell_clear       = 1'b0;
        cell_load        = 1'b0;
        capture          = 1'b0;
        push             = 1'b0;
        push_sym         = pend_sym_reg;
        push_bad         = pend_bad_reg;
        push_last        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (s_axis_tuser)
                        REQ_CLEAR:
                        begin
                            cell_clear       = 1'b1;
                            acc_bits_next    = '0;
                            acc_len_next     = '0;
                            pad_next         = '0;
                            header_seen_next = 1'b0;
                            rejected_next    = 1'b0;
                            stuck_next       = 1'b0;
                        end
                        REQ_LOAD:
                        begin
                            cell_load = load_ok;
                        end
                        REQ_DATA:
                        begin
                            if (!rejected_reg)
                            begin
                                if (!header_seen_reg)
                                begin
                                    header_seen_next = 1'b1;
                                    if (in_byte > DATA_W'(PAD_MAX))
                                    begin
                                        rejected_next   = 1'b1;
                                        pend_valid_next = 1'b1;
                                        pend_bad_next   = 1'b1;
                                        pend_sym_next   = '0;
                                        state_next      = ST_FLUSH;
                                    end
                                    else
                                    begin
                                        pad_next = in_byte[PAD_W-1:0];
                                    end
                                end
                                else
                                begin
                                    byte_next      = in_byte;
                                    bits_left_next = BCNT_W'(BYTE_BITS)
                                                   - (s_axis_tlast ? BCNT_W'(pad_reg) : '0);
                                    state_next     = ST_STEP;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
            end
            ST_MATCH:
            begin
                capture    = 1'b1;
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                if (take_hit)
                begin
                    // the held symbol is not the last one, a newer hit follows it
                    push            = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_sym_next   = hit_idx;
                    pend_bad_next   = 1'b0;
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    if (slot_free)
                    begin
                        push            = 1'b1;
                        push_last       = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // feed the next code bit into the accumulator, or flush when the byte is spent or the accumulator is full
        if (do_step)
        begin
            acc_len_next  = acc_len_eff;
            acc_bits_next = acc_bits_eff;
            priority if ((bits_left_reg == '0) || stuck_reg)
            begin
                state_next = ST_FLUSH;
            end
            else if (acc_len_eff == ACC_LEN_W'(MAX_CODE_LEN))
            begin
                stuck_next = 1'b1;
                state_next = ST_FLUSH;
            end
            else
            begin
                acc_bits_next  = {acc_bits_eff[CODE_W-2:0], byte_reg[DATA_W-1]};
                acc_len_next   = acc_len_eff + ACC_LEN_W'(1);
                byte_next      = byte_reg << 1;
                bits_left_next = bits_left_reg - BCNT_W'(1);
                state_next     = ST_MATCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            acc_bits_reg    <= '0;
            acc_len_reg     <= '0;
            pad_reg         <= '0;
            header_seen_reg <= 1'b0;
            rejected_reg    <= 1'b0;
            stuck_reg       <= 1'b0;
            bits_left_reg   <= '0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            acc_bits_reg    <= acc_bits_next;
            acc_len_reg     <= acc_len_next;
            pad_reg         <= pad_next;
            header_seen_reg <= header_seen_next;
            rejected_reg    <= rejected_next;
            stuck_reg       <= stuck_next;
            bits_left_reg   <= bits_left_next;
            pend_valid_reg  <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        pend_sym_reg <= pend_sym_next;
        pend_bad_reg <= pend_bad_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_sym_reg  <= SYM_W'(push_sym);
            out_bad_reg  <= push_bad;
            out_last_reg <= push_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sym_reg;
    assign m_axis_tuser  = out_bad_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* hw/rtl/pscd_checker.sv */
`default_nettype none
`include "prefix_code_stream_decoder_unit_defines.svh"

module pscd_checker import pscd_pkg::*; (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic [REQ_W-1:0]     s_axis_tuser,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                 m_axis_tuser,
    input wire logic                 m_axis_tlast
);

    // a held result keeps its contents
    `PSCD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

    // a rejected header is reported alone with a zero symbol
    `PSCD_ASSERT(a_bad_hdr, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0 && m_axis_tlast), "bad header result malformed")

    // after clear, load and unknown requests s_axis_tready is high again in the next cycle
    `PSCD_ASSERT_NEXT(a_ctrl_single, s_axis_tvalid && s_axis_tready && s_axis_tuser != REQ_DATA, s_axis_tready, "busy after non-data transfer")

    // the decoder only goes busy after a data transfer
    `PSCD_ASSERT(a_busy_cause, $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tuser == REQ_DATA), "busy without data transfer")

endmodule

bind prefix_code_stream_decoder_unit pscd_checker u_pscd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
